// ----- rtl/core/json_string_unescaper_macros.svh -----
// ----------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define JSU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define JSU_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Result kinds, error codes and the command word passed front to back.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_EXPECT_QUOTE = 3'd1;
   localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX      = 3'd3;
   localparam logic [2:0] ERR_UNTERMINATED = 3'd4;

   // one command expands to last_idx+1 result words
   typedef struct packed {
      logic [1:0] last_idx;
      logic [7:0] byte2;
      logic [7:0] byte1;
      logic [7:0] byte0;
      logic [1:0] kind;
      logic [2:0] err;
   } cmd_type;

endpackage

// ----- rtl/core/jsu_front.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper front end
// Parses text bytes and issues one command per byte that yields results.
// ----------------------------------------------------------------------------
`include "json_string_unescaper_macros.svh"

module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       text_byte,
   output logic             push,
   output jsu_pkg::cmd_type push_cmd
);
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      PH_EXPECT = 3'd0,
      PH_BODY   = 3'd1,
      PH_ESC    = 3'd2,
      PH_HEX    = 3'd3
   } phase_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;

   localparam logic [7:0] UTF8_CONT  = 8'h80;
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;

   phase_type   phase_ff, phase_in;
   logic [15:0] code_point_ff, code_point_in;
   logic [1:0]  hex_count_ff, hex_count_in;

   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] cp_full;
   logic        emit;
   cmd_type     cmd;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
         hex_val = text_byte[3:0];
      end else if ((text_byte >= 8'h61 && text_byte <= 8'h66) ||
                   (text_byte >= 8'h41 && text_byte <= 8'h46)) begin
         hex_val = 4'(text_byte[2:0] + 3'd1) + 4'd8;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign cp_full = {code_point_ff[11:0], hex_val};

   always_comb begin
      phase_in      = phase_ff;
      code_point_in = code_point_ff;
      hex_count_in  = hex_count_ff;
      emit          = 1'b0;
      cmd           = '0;
      unique case (phase_ff)
         PH_BODY: begin
            if (text_byte == CH_NUL) begin
               emit     = 1'b1;
               cmd.kind = KIND_ERROR;
               cmd.err  = ERR_UNTERMINATED;
               phase_in = PH_EXPECT;
            end else if (text_byte == CH_QUOTE) begin
               emit     = 1'b1;
               cmd.kind = KIND_CLOSE;
               phase_in = PH_EXPECT;
            end else if (text_byte == CH_BSL) begin
               phase_in = PH_ESC;
            end else begin
               emit      = 1'b1;
               cmd.byte0 = text_byte;
            end
         end
         PH_ESC: begin
            emit     = 1'b1;
            phase_in = PH_BODY;
            unique case (text_byte)
               CH_QUOTE: cmd.byte0 = CH_QUOTE;
               CH_BSL:   cmd.byte0 = CH_BSL;
               CH_SLASH: cmd.byte0 = CH_SLASH;
               CH_B:     cmd.byte0 = 8'h08;
               CH_F:     cmd.byte0 = 8'h0C;
               CH_N:     cmd.byte0 = 8'h0A;
               CH_R:     cmd.byte0 = 8'h0D;
               CH_T:     cmd.byte0 = 8'h09;
               CH_U: begin
                  emit     = 1'b0;
                  phase_in = PH_HEX;
               end
               default: begin
                  cmd.kind = KIND_ERROR;
                  cmd.err  = ERR_BAD_ESCAPE;
                  phase_in = PH_EXPECT;
               end
            endcase
         end
         PH_HEX: begin
            if (!hex_ok) begin
               emit     = 1'b1;
               cmd.kind = KIND_ERROR;
               cmd.err  = ERR_BAD_HEX;
               phase_in = PH_EXPECT;
            end else if (hex_count_ff != 2'd3) begin
               code_point_in = cp_full;
               hex_count_in  = hex_count_ff + 2'd1;
            end else begin
               emit     = 1'b1;
               phase_in = PH_BODY;
               if (cp_full < 16'h0080) begin
                  cmd.byte0 = cp_full[7:0];
               end else if (cp_full < 16'h0800) begin
                  cmd.last_idx = 2'd1;
                  cmd.byte0    = UTF8_LEAD2 | {3'd0, cp_full[10:6]};
                  cmd.byte1    = UTF8_CONT | {2'd0, cp_full[5:0]};
               end else begin
                  cmd.last_idx = 2'd2;
                  cmd.byte0    = UTF8_LEAD3 | {4'd0, cp_full[15:12]};
                  cmd.byte1    = UTF8_CONT | {2'd0, cp_full[11:6]};
                  cmd.byte2    = UTF8_CONT | {2'd0, cp_full[5:0]};
               end
            end
         end
         default: begin
            if (text_byte == CH_QUOTE) begin
               phase_in = PH_BODY;
            end else begin
               emit     = 1'b1;
               cmd.kind = KIND_ERROR;
               cmd.err  = ERR_EXPECT_QUOTE;
               phase_in = PH_EXPECT;
            end
         end
      endcase
      // code point and digit count live only while reading hex
      if (phase_in != PH_HEX || phase_ff != PH_HEX) begin
         code_point_in = (phase_in == PH_HEX && phase_ff == PH_HEX) ? code_point_in : 16'd0;
         hex_count_in  = (phase_in == PH_HEX && phase_ff == PH_HEX) ? hex_count_in : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_EXPECT;
         code_point_ff <= 16'd0;
         hex_count_ff  <= 2'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         code_point_ff <= code_point_in;
         hex_count_ff  <= hex_count_in;
      end
   end

   assign push     = accept && emit;
   assign push_cmd = cmd;

   `JSU_ASSERT_NEXT(a_err_rearms, clock, reset, push && push_cmd.kind == KIND_ERROR, phase_ff == PH_EXPECT)
   `JSU_ASSERT_IMPL(a_digits_in_hex, clock, reset, hex_count_ff != 2'd0, phase_ff == PH_HEX)
   `JSU_ASSERT_IMPL(a_multi_is_byte, clock, reset, push && push_cmd.last_idx != 2'd0, push_cmd.kind == KIND_BYTE)

endmodule

// ----- rtl/core/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper command queue
// Small register FIFO decoupling the parser from the result sequencer.
// ----------------------------------------------------------------------------
`include "json_string_unescaper_macros.svh"

module jsu_queue #(
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output jsu_pkg::cmd_type head_cmd
);
   import jsu_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   cmd_type               entry_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CountWidth-1:0] count_ff;

   function automatic logic [PtrWidth-1:0] bump(input logic [PtrWidth-1:0] p);
      logic [PtrWidth-1:0] r;
      r = (p == PtrWidth'(Depth - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   assign full       = (count_ff == CountWidth'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `JSU_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CountWidth'(Depth))
   `JSU_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, head_valid)
   `JSU_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ----- rtl/core/jsu_back.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper result sequencer
// Expands queued commands into result words through an output register.
// ----------------------------------------------------------------------------
`include "json_string_unescaper_macros.svh"

module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  jsu_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_data_byte,
   output logic [1:0]       rsp_kind,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_last_of_run
);
   import jsu_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic [1:0] kind_ff;
   logic [2:0] err_ff;
   logic       last_ff;

   logic       load;
   logic       at_last;
   logic [7:0] sel_byte;

   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign at_last = (idx_ff == head_cmd.last_idx);
   assign pop     = load && at_last;

   always_comb begin
      case (idx_ff)
         2'd1:    sel_byte = head_cmd.byte1;
         2'd2:    sel_byte = head_cmd.byte2;
         default: sel_byte = head_cmd.byte0;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         idx_in   = at_last ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= sel_byte;
         kind_ff <= head_cmd.kind;
         err_ff  <= head_cmd.err;
         last_ff <= at_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_data_byte   = data_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_error_code  = err_ff;
   assign rsp_last_of_run = last_ff;

   `JSU_ASSERT_IMPL(a_event_is_last, clock, reset, valid_ff && kind_ff != KIND_BYTE, last_ff)
   `JSU_ASSERT_IMPL(a_err_code_kind, clock, reset, valid_ff && err_ff != ERR_NONE, kind_ff == KIND_ERROR)
   `JSU_ASSERT_IMPL(a_idx_in_range, clock, reset, head_valid, idx_ff <= head_cmd.last_idx)

endmodule

// ----- rtl/core/json_string_unescaper.sv -----
// ----------------------------------------------------------------------------
// JSON string unescaper
// Decodes JSON string text into raw bytes, with UTF-8 for \u escapes.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one text byte per word, starting at the opening quote.
//     A zero byte marks end of text. A word is taken when req_valid is high
//     and req_stall is low.
//   rsp_ channel: result words carrying a decoded byte, a string-closed mark
//     or an error code. rsp_last_of_run flags the final word caused by one
//     input byte. The receiver holds rsp_stall high to hold a word.
//   Path: a taken byte is written as a command into the command queue, then
//     its first result word passes through the output register onto rsp_.
//   Throughput: one input word per cycle while req_stall is low. Every byte
//     gives at most one word, except the last hex digit of a \u escape, which
//     gives one to three; the output register drains one word per cycle
//     while rsp_stall is low, so those extra words are absorbed by the
//     command queue (QUEUE_DEPTH entries) between the parser and the result
//     sequencer. req_stall rises only when that queue is full.
//   Reset: synchronous; the parser waits for an opening quote, the queue is
//     emptied and rsp_valid drops.
//   Back-pressure: a stalled result word holds; the parser keeps taking
//   bytes until the queue fills.
// ----------------------------------------------------------------------------
module json_string_unescaper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last_of_run
);
   import jsu_pkg::*;

   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   // front end stalls only on a full queue
   assign req_stall = full;
   assign accept    = req_valid && !full;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   jsu_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // one result word per cycle out of the head command while rsp_stall is low
   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_kind        (rsp_kind),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
